// File: src/bse_pkg.sv
`default_nettype none

package bse_pkg;

  localparam int VALUE_BITS = 8;

  typedef struct packed {
    logic shift;
    logic insert_block;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/bse_cell.sv
`default_nettype none

module bse_cell #(
  parameter int DATA_BITS = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  bse_pkg::cell_ctrl_t   ctrl,
  input  wire                   tok_in_v,
  input  wire  [DATA_BITS-1:0]  tok_in_d,
  input  wire                   nbr_v,
  input  wire  [DATA_BITS-1:0]  nbr_d,
  output logic                  held_v,
  output logic [DATA_BITS-1:0]  held_d,
  output logic                  tok_out_v,
  output logic [DATA_BITS-1:0]  tok_out_d
);
  import bse_pkg::*;

  logic                 held_v_r, held_v_nxt;
  logic [DATA_BITS-1:0] held_d_r, held_d_nxt;
  logic                 tok_v_r, tok_v_nxt;
  logic [DATA_BITS-1:0] tok_d_r, tok_d_nxt;

  always_comb begin
    held_v_nxt = held_v_r;
    held_d_nxt = held_d_r;
    tok_v_nxt  = 1'b0;
    tok_d_nxt  = tok_d_r;
    if (ctrl.shift) begin
      held_v_nxt = nbr_v;
      held_d_nxt = nbr_d;
    end else if (tok_in_v && !ctrl.insert_block) begin
      if (!held_v_r) begin
        held_v_nxt = 1'b1;
        held_d_nxt = tok_in_d;
      end else if (tok_in_d < held_d_r) begin
        // keep the smaller value, push the displaced one on
        held_d_nxt = tok_in_d;
        tok_v_nxt  = 1'b1;
        tok_d_nxt  = held_d_r;
      end else begin
        tok_v_nxt = 1'b1;
        tok_d_nxt = tok_in_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      tok_v_r  <= 1'b0;
    end else begin
      held_v_r <= held_v_nxt;
      tok_v_r  <= tok_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_d_r <= held_d_nxt;
    tok_d_r  <= tok_d_nxt;
  end

  assign held_v    = held_v_r;
  assign held_d    = held_d_r;
  assign tok_out_v = tok_v_r;
  assign tok_out_d = tok_d_r;

endmodule

`default_nettype wire

// File: src/bubble_sort_engine_unit.sv
// one input transaction per cycle while a set loads; each value sorts into a row of cells
// as it travels, one cell per cycle
// after the closing transaction the row settles until no value travels, then the sorted
// set leaves at one output transaction per cycle while out_stall is low; the ripple
// through the cell row sets the settle time
// synchronous active-low reset empties the row and clears the count; no clearing pass
`default_nettype none

module bubble_sort_engine_unit #(
  parameter int MAX_ITEMS = 16,
  parameter int DATA_BITS = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [bse_pkg::VALUE_BITS-1:0] in_value,
  input  wire                            in_last_in,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [bse_pkg::VALUE_BITS-1:0] out_sorted_value,
  output logic                           out_last_out
);
  import bse_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SETTLE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                 held_v [MAX_ITEMS+1];
  logic [DATA_BITS-1:0] held_d [MAX_ITEMS+1];
  logic                 tok_v  [MAX_ITEMS+1];
  logic [DATA_BITS-1:0] tok_d  [MAX_ITEMS+1];
  logic [MAX_ITEMS-1:0] busy_vec;

  cell_ctrl_t ctrl;
  logic       in_acc, out_acc, full, in_flight;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign full    = (count_r == CW'(MAX_ITEMS));

  assign ctrl.shift        = out_acc;
  assign ctrl.insert_block = 1'b0;

  assign tok_v[0] = in_acc && !full;
  assign tok_d[0] = DATA_BITS'(in_value);

  assign held_v[MAX_ITEMS] = 1'b0;
  assign held_d[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    bse_cell #(
      .DATA_BITS(DATA_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .tok_in_v (tok_v[i]),
      .tok_in_d (tok_d[i]),
      .nbr_v    (held_v[i+1]),
      .nbr_d    (held_d[i+1]),
      .held_v   (held_v[i]),
      .held_d   (held_d[i]),
      .tok_out_v(tok_v[i+1]),
      .tok_out_d(tok_d[i+1])
    );
    assign busy_vec[i] = tok_v[i+1];
  end

  assign in_flight = |busy_vec;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
          if (in_last_in) begin
            state_nxt = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        if (!in_flight) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign in_stall         = (state_r != ST_LOAD);
  assign out_valid        = (state_r == ST_EMIT);
  assign out_sorted_value = VALUE_BITS'(held_d[0]);
  assign out_last_out     = (count_r == CW'(1));

  // head cell must hold a value whenever a result is offered
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> held_v[0])
    else $error("emit with empty head cell");

  // no value may still be travelling while results go out
  a_settled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_flight)
    else $error("emit while the row is still settling");

  // final result returns the block to loading
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_out) |=> (!out_valid && !in_stall && count_r == '0))
    else $error("set did not close after final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

endmodule

`default_nettype wire
